[rtl/rpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants of the random pixel dissolve sequencer.
// ----------------------------------------------------------------------------
package rpd_pkg;

    // Input opcodes
    localparam logic OPC_START = 1'b0;
    localparam logic OPC_STEP  = 1'b1;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     RESET_SIDE       = 11'd512;

    // Result field widths
    localparam int PIX_W   = 20;
    localparam int COORD_W = 10;

    // Epoch tag kept beside each table entry, and multiplier chunk width
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;
    localparam int CHUNK_W = 16;

    typedef enum logic {
        K_START,
        K_STEP
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_RDR,
        S_RDK,
        S_WR,
        S_DIV,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

[rtl/rpd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rpd_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1048576
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/rpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_front
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module rpd_front
    import rpd_pkg::*;
#(
    parameter int FRACTION_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_opcode,
    input  wire logic [FRACTION_BITS-1:0] i_random_fraction,
    output logic                          o_head_valid,
    output t_kind                         o_head_kind,
    output logic      [FRACTION_BITS-1:0] o_head_frac,
    input  wire logic                     i_pop
);

    t_kind                    r_kind [2];
    logic [FRACTION_BITS-1:0] r_frac [2];
    logic                     r_wp, r_rp;
    logic [1:0]               r_cnt;
    logic                     w_push, w_pop;

    assign o_in_stall   = (r_cnt == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_cnt != 2'd0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head_kind  = r_kind[r_rp];
    assign o_head_frac  = r_frac[r_rp];

    // Store the classified transaction
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wp] <= (i_opcode == OPC_START) ? K_START : K_STEP;
            r_frac[r_wp] <= i_random_fraction;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

[rtl/rpd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_back
// Shuffle sequencer: slot pick by chunked multiply, table read-modify-write
// with epoch-tagged entries, bit-serial divide for x and y, output register.
// ----------------------------------------------------------------------------
module rpd_back
    import rpd_pkg::*;
#(
    parameter int MAX_SIDE      = 1024,
    parameter int FRACTION_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [CFG_W-1:0]         i_frame_width,
    input  wire logic [CFG_W-1:0]         i_frame_height,
    input  wire logic                     i_head_valid,
    input  wire t_kind                    i_head_kind,
    input  wire logic [FRACTION_BITS-1:0] i_head_frac,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic      [PIX_W-1:0]         o_pixel_index,
    output logic      [COORD_W-1:0]       o_pixel_x,
    output logic      [COORD_W-1:0]       o_pixel_y,
    output logic                          o_final_pixel
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int NCH   = (FRACTION_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int FBP   = NCH * CHUNK_W;
    localparam int SUMW  = CW + CHUNK_W + 1;
    localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int DCW   = $clog2(AW);
    localparam int DW    = AW + EPOCH_W;

    // Clamp a side register to [1, MAX_SIDE]
    function automatic logic [SW-1:0] eff_side(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v == '0)
            eff_side = SW'(1);
        else if (v32 > 32'(MAX_SIDE))
            eff_side = SW'(MAX_SIDE);
        else
            eff_side = SW'(v);
    endfunction

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [AW-1:0]     r_clr, n_clr;
    logic [CW-1:0]     r_n, n_n;
    logic [FBP-1:0]    r_f, n_f;
    logic [CIW-1:0]    r_ci, n_ci;
    logic [CW:0]       r_acc, n_acc;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_r, n_r;
    logic [AW-1:0]     r_picked, n_picked;
    logic [AW-1:0]     r_dvd, n_dvd;
    logic [AW-1:0]     r_quo, n_quo;
    logic [SW-1:0]     r_rem, n_rem;
    logic [DCW-1:0]    r_dc, n_dc;
    logic [SW-1:0]     r_w, n_w;
    logic              r_final, n_final;
    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_oidx, n_oidx;
    logic [COORD_W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic              r_ofin, n_ofin;

    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [DW-1:0]     w_wdata, w_rdata;
    logic              w_hit;
    logic [AW-1:0]     w_loc;
    logic [AW-1:0]     w_rsel;
    logic [SUMW-1:0]   w_sum;
    logic [SW:0]       w_trial;
    logic              w_ge;
    logic [2*SW-1:0]   w_area;

    rpd_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Entry is live only if tagged with the current epoch
    assign w_loc = w_rdata[AW-1:0];
    assign w_hit = (w_rdata[AW +: EPOCH_W] == r_epoch);

    // Slot pick, clamped to at most the decremented count
    assign w_rsel = (r_acc > (CW+1)'(r_k)) ? r_k : AW'(r_acc);

    // One partial product per cycle, accumulated from the low chunk up
    assign w_sum = SUMW'(r_acc) + SUMW'(r_n * r_f[CHUNK_W-1:0]);

    // Restoring divide step
    assign w_trial = {r_rem, r_dvd[AW-1]};
    assign w_ge    = (w_trial >= (SW+1)'(r_w));

    assign w_area = eff_side(i_frame_width) * eff_side(i_frame_height);

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_epoch     = r_epoch;
        n_clr       = r_clr;
        n_n         = r_n;
        n_f         = r_f;
        n_ci        = r_ci;
        n_acc       = r_acc;
        n_k         = r_k;
        n_r         = r_r;
        n_picked    = r_picked;
        n_dvd       = r_dvd;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dc        = r_dc;
        n_w         = r_w;
        n_final     = r_final;
        n_out_valid = r_out_valid && i_out_stall;
        n_oidx      = r_oidx;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_ofin      = r_ofin;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_r;
        w_wdata     = {r_epoch, w_loc};
        w_raddr     = r_k;

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_epoch = EPOCH_FIRST;
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (i_head_kind == K_START) begin
                        n_count = CW'(w_area);
                        if (r_epoch == EPOCH_LAST) begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end else if (r_count != '0) begin
                        n_n     = r_count;
                        n_k     = AW'(r_count - 1'b1);
                        n_f     = FBP'(i_head_frac) << (FBP - FRACTION_BITS);
                        n_acc   = '0;
                        n_ci    = '0;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_acc = (CW+1)'(w_sum >> CHUNK_W);
                n_f   = r_f >> CHUNK_W;
                n_ci  = r_ci + 1'b1;
                if (r_ci == CIW'(NCH - 1)) begin
                    n_state = S_RDR;
                end
            end
            S_RDR: begin
                w_raddr = w_rsel;
                n_r     = w_rsel;
                n_state = S_RDK;
            end
            S_RDK: begin
                w_raddr  = r_k;
                n_picked = w_hit ? w_loc : r_r;
                n_state  = S_WR;
            end
            S_WR: begin
                w_we    = 1'b1;
                w_waddr = r_r;
                w_wdata = {r_epoch, (w_hit ? w_loc : r_k)};
                n_count = CW'(r_k);
                n_final = (r_k == '0);
                n_dvd   = r_picked;
                n_w     = eff_side(i_frame_width);
                n_rem   = '0;
                n_dc    = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_ge ? SW'(w_trial - (SW+1)'(r_w)) : SW'(w_trial);
                n_quo = {r_quo[AW-2:0], w_ge};
                n_dvd = r_dvd << 1;
                n_dc  = r_dc + 1'b1;
                if (r_dc == DCW'(AW - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_oidx      = PIX_W'(r_picked);
                    n_ox        = COORD_W'(r_rem);
                    n_oy        = COORD_W'(r_quo);
                    n_ofin      = r_final;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_epoch     <= EPOCH_FIRST;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_epoch     <= n_epoch;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_f      <= n_f;
        r_ci     <= n_ci;
        r_acc    <= n_acc;
        r_k      <= n_k;
        r_r      <= n_r;
        r_picked <= n_picked;
        r_dvd    <= n_dvd;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dc     <= n_dc;
        r_w      <= n_w;
        r_final  <= n_final;
        r_oidx   <= n_oidx;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_ofin   <= n_ofin;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_oidx;
    assign o_pixel_x     = r_ox;
    assign o_pixel_y     = r_oy;
    assign o_final_pixel = r_ofin;

    // The table write always follows the read of slot k
    a_wr_after_rdk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> $past(r_state) == S_RDK)
        else $error("table write without preceding read");

    // Epoch zero marks cleared entries and is never live
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |-> r_epoch != '0)
        else $error("epoch zero in use");

    // Scaled fraction lies below the count
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RDR |-> r_acc < (CW+1)'(r_n))
        else $error("slot pick out of range");

endmodule
`default_nettype wire

[rtl/random_pixel_dissolve_order.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// random_pixel_dissolve_order
// Random-order pixel dissolve sequencer: emits each pixel of a frame once.
// ----------------------------------------------------------------------------
// A start transaction loads the frame size; each step transaction then
// yields one pixel (linear index, x, y, last flag) until the frame is done.
// A step runs the 16-bit chunked slot multiply, two reads and one write of
// the location table (which has a single read port), and the
// one-bit-per-cycle divider for x and y. After reset, and on every 255th
// start, a clearing pass sweeps all MAX_SIDE^2 table entries; input
// transactions queue (two deep) and then stall during it.
// ----------------------------------------------------------------------------
module random_pixel_dissolve_order
    import rpd_pkg::*;
#(
    parameter int MAX_SIDE      = 1024,
    parameter int FRACTION_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_opcode,
    input  wire logic [FRACTION_BITS-1:0] i_random_fraction,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic      [PIX_W-1:0]         o_pixel_index,
    output logic      [COORD_W-1:0]       o_pixel_x,
    output logic      [COORD_W-1:0]       o_pixel_y,
    output logic                          o_final_pixel
);

    logic [CFG_W-1:0]         r_frame_width, r_frame_height;
    logic                     w_head_valid, w_pop;
    t_kind                    w_head_kind;
    logic [FRACTION_BITS-1:0] w_head_frac;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_SIDE;
            r_frame_height <= RESET_SIDE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_FRAME_WIDTH)  r_frame_width  <= i_cfg_data;
            if (i_cfg_index == REG_FRAME_HEIGHT) r_frame_height <= i_cfg_data;
        end
    end

    rpd_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_random_fraction (i_random_fraction),
        .o_head_valid      (w_head_valid),
        .o_head_kind       (w_head_kind),
        .o_head_frac       (w_head_frac),
        .i_pop             (w_pop)
    );

    rpd_back #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_head_valid   (w_head_valid),
        .i_head_kind    (w_head_kind),
        .i_head_frac    (w_head_frac),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_final_pixel  (o_final_pixel)
    );

endmodule
`default_nettype wire
